// File: rtl/core/ray_pixel_key_sorter_top_defines.svh
// Assertion macros used by the checker of the pixel key sorter.
`ifndef RAY_PIXEL_KEY_SORTER_TOP_DEFINES_SVH
`define RAY_PIXEL_KEY_SORTER_TOP_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define RPKS_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define RPKS_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// File: rtl/core/rpks_pkg.sv
// ----------------------------------------------------------------------------
// rpks_pkg
// Shared types and constants of the ray pixel key sorter.
// ----------------------------------------------------------------------------
package rpks_pkg;
   localparam int RayDepth = 32;
   localparam int IdxW     = $clog2(RayDepth);
   localparam int CntW     = $clog2(RayDepth + 1);
   localparam int KeyW     = 20;
   localparam int PixW     = 24;
   localparam int EntW     = PixW + KeyW;

   localparam logic [1:0] MODE_LUM  = 2'd0;
   localparam logic [1:0] MODE_NLUM = 2'd1;
   localparam logic [1:0] MODE_HUE  = 2'd2;
   localparam logic [1:0] MODE_SAT  = 2'd3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       last_out;
   } rsp_type;

   // Key plus pixel, as held in the store.
   typedef struct packed {
      logic signed [KeyW-1:0] key;
      logic [PixW-1:0]        pix;
   } entry_type;
endpackage

// File: rtl/core/rpks_stream_if.sv
// ----------------------------------------------------------------------------
// rpks_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface rpks_stream_if #(parameter type T = logic);
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/rpks_key_unit.sv
// ----------------------------------------------------------------------------
// rpks_key_unit
// Key computation: luminance keys directly, hue and saturation by a restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rpks_key_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [1:0]                       mode,
   input  logic [7:0]                       r,
   input  logic [7:0]                       g,
   input  logic [7:0]                       b,
   output logic                             done,
   output logic signed [rpks_pkg::KeyW-1:0] key
);
   import rpks_pkg::*;

   logic [7:0]  mx, mn, d;
   logic [10:0] num;
   logic [17:0] lum;
   logic [7:0]  div_in, div_ff;
   logic [10:0] num_in;
   logic        zero_in;
   logic [26:0] rem_ff, rem_in;
   logic [19:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic signed [KeyW-1:0] key_ff, key_in;
   logic [27:0] trial;

   // Operand decode.
   always_comb begin
      mx  = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
      mn  = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
      d   = mx - mn;
      lum = 18'(299 * r) + 18'(587 * g) + 18'(114 * b);
      if (mx == r)
         num = (g >= b) ? 11'(g - b) : 11'(11'(6 * d) - 11'(b - g));
      else if (mx == g)
         num = 11'(11'(2 * d) + 11'(b) - 11'(r));
      else
         num = 11'(11'(4 * d) + 11'(r) - 11'(g));
      if (mode == MODE_HUE) begin
         div_in = d; num_in = num; zero_in = (d == 8'd0);
      end else begin
         div_in = mx; num_in = 11'(d); zero_in = (mx == 8'd0);
      end
   end

   // Divider iteration over 20 quotient bits, numerator shifted by 16.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      key_in  = key_ff;
      trial   = '0;
      if (start) begin
         case (mode)
            MODE_LUM:  begin key_in = KeyW'($signed({2'b0, lum})); done_in = 1'b1; end
            MODE_NLUM: begin key_in = -KeyW'($signed({2'b0, lum})); done_in = 1'b1; end
            default: begin
               if (zero_in) begin
                  key_in = '0; done_in = 1'b1;
               end else begin
                  rem_in = {num_in, 16'b0}; quo_in = '0; cnt_in = '0; busy_in = 1'b1;
               end
            end
         endcase
      end else if (busy_ff) begin
         trial = {1'b0, rem_ff} - ({20'b0, div_ff} << (5'd19 - cnt_ff));
         quo_in = {quo_ff[18:0], ~trial[27]};
         if (!trial[27]) rem_in = trial[26:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd19) begin
            busy_in = 1'b0; done_in = 1'b1;
            key_in  = $signed({quo_ff[18:0], ~trial[27]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; cnt_ff <= cnt_in; key_ff <= key_in;
      if (start) div_ff <= div_in;
   end

   assign done = done_ff;
   assign key  = key_ff;
endmodule

// File: rtl/core/ray_pixel_key_sorter_top.sv
// ----------------------------------------------------------------------------
// ray_pixel_key_sorter_top
// Stable insertion sort of a pixel run by a configurable fixed-point key.
// ----------------------------------------------------------------------------
// Luminance keys come straight from the key unit; hue and saturation keys
// come from its bit-serial divider. Each stored entry that moves up during
// insertion is read and then written back, since the store has one read and
// one write port. A pixel that arrives while the store is full is dropped.
// On a last beat the run is then read out, and each next entry is read only
// once the sink has taken the beat before. Pixels beyond 32 entries are dropped.
module ray_pixel_key_sorter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata,
   rpks_stream_if.sink   req,
   rpks_stream_if.source rsp
);
   import rpks_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001, ST_KEY = 6'b000010, ST_SCAN = 6'b000100,
      ST_MOVE = 6'b001000, ST_EMIT = 6'b010000, ST_DRAIN = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]  mode_ff;
   logic [CntW-1:0] cnt_ff, cnt_in, pos_ff, pos_in, rd_ff, rd_in;
   logic [PixW-1:0] pix_ff;
   logic        last_ff;
   logic signed [KeyW-1:0] newkey_ff;
   entry_type   mem [RayDepth];
   entry_type   rdata_ff;
   logic [IdxW-1:0] raddr;
   logic        ren;
   logic        we;
   logic [IdxW-1:0] waddr;
   entry_type   wdata;
   logic        ku_start, ku_done;
   logic signed [KeyW-1:0] ku_key;
   logic        kick_ff;
   logic        rvld_ff, rvld_in;
   rsp_type     out_ff;
   logic        ovld_ff, ovld_in;
   logic        take;

   rpks_key_unit u_key (
      .clock(clock), .reset(reset), .start(ku_start), .mode(mode_ff),
      .r(pix_ff[23:16]), .g(pix_ff[15:8]), .b(pix_ff[7:0]),
      .done(ku_done), .key(ku_key)
   );

   // Config register.
   always_ff @(posedge clock) begin
      if (reset) mode_ff <= MODE_LUM;
      else if (csr_we) mode_ff <= csr_wdata;
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign take = req.valid && req.ready;
   // The key unit is started once, in the first cycle after a pixel is taken into a store that is not full.
   assign ku_start = kick_ff;

   // Sequencer.
   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; pos_in = pos_ff; rd_in = rd_ff;
      ren = 1'b0; raddr = '0; we = 1'b0; waddr = '0; wdata = '0;
      rvld_in = 1'b0; ovld_in = ovld_ff;
      if (ovld_ff && rsp.ready) ovld_in = 1'b0;
      case (state_ff)
         ST_IDLE: if (take) begin
            if (cnt_ff < CntW'(RayDepth)) begin
               state_in = ST_KEY;
            end else if (req.data.last_in) begin
               state_in = ST_EMIT; rd_in = '0;
            end
         end
         ST_KEY: if (ku_done) begin
            pos_in = cnt_ff; state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // Read the entry just below the insertion point.
            if (pos_ff == '0) state_in = ST_MOVE;
            else begin
               ren = 1'b1; raddr = IdxW'(pos_ff - CntW'(1)); rvld_in = 1'b1;
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            if (rvld_ff && rdata_ff.key > newkey_ff) begin
               we = 1'b1; waddr = IdxW'(pos_ff); wdata = rdata_ff;
               pos_in = pos_ff - CntW'(1); state_in = ST_SCAN;
            end else begin
               we = 1'b1; waddr = IdxW'(pos_ff);
               wdata.key = newkey_ff; wdata.pix = pix_ff;
               cnt_in = cnt_ff + CntW'(1);
               if (last_ff) begin state_in = ST_EMIT; rd_in = '0; end
               else state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rd_ff == cnt_ff) begin
               cnt_in = '0; state_in = ST_IDLE;
            end else if (!ovld_in) begin
               ren = 1'b1; raddr = IdxW'(rd_ff); rvld_in = 1'b1;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            ovld_in = 1'b1; rd_in = rd_ff + CntW'(1); state_in = ST_EMIT;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Entry store, one read and one write port.
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (ren) rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; cnt_ff <= '0; ovld_ff <= 1'b0; rvld_ff <= 1'b0;
         kick_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; ovld_ff <= ovld_in;
         rvld_ff <= rvld_in;
         kick_ff <= take && (cnt_ff < CntW'(RayDepth));
      end
      pos_ff <= pos_in; rd_ff <= rd_in;
      if (take) begin
         pix_ff  <= {req.data.red, req.data.green, req.data.blue};
         last_ff <= req.data.last_in;
      end
      if (ku_done) newkey_ff <= ku_key;
      if (state_ff == ST_DRAIN) begin
         out_ff.red_out   <= rdata_ff.pix[23:16];
         out_ff.green_out <= rdata_ff.pix[15:8];
         out_ff.blue_out  <= rdata_ff.pix[7:0];
         out_ff.last_out  <= (rd_ff + CntW'(1) == cnt_ff);
      end
   end

   assign rsp.valid = ovld_ff;
   assign rsp.data  = out_ff;
endmodule

// File: rtl/core/rpks_checker.sv
// ----------------------------------------------------------------------------
// rpks_checker
// Port-level checks of the pixel key sorter.
// ----------------------------------------------------------------------------
`include "ray_pixel_key_sorter_top_defines.svh"
module rpks_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);
   // A stalled result beat stays offered.
   `RPKS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // A stalled result beat keeps its last flag.
   `RPKS_ASSERT_NXT(a_last_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_last))
   // Valid drops after each taken result beat, before the next one is offered.
   `RPKS_ASSERT_NXT(a_rsp_gap, clock, reset, rsp_valid && rsp_ready, !rsp_valid)
   // A new result beat is only raised while the input side is closed.
   `RPKS_ASSERT_IMP(a_rise_busy, clock, reset, $rose(rsp_valid), !req_ready)
endmodule

bind ray_pixel_key_sorter_top rpks_checker u_chk (
   .clock(clock), .reset(reset), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_last(rsp.data.last_out)
);

// File: tb/sv/ray_pixel_key_sorter_top_tb.sv
// ----------------------------------------------------------------------------
// ray_pixel_key_sorter_top_tb
// Drives pixel runs with random gaps into the sorter under each key mode,
// predicts the stable ascending order of every run, and checks each sorted
// output beat field by field against the expected pixel stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ray_pixel_key_sorter_top_tb;
   import rpks_pkg::*;

   localparam int CycleLimit = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [1:0] csr_wdata = MODE_LUM;

   rpks_stream_if #(.T(req_type)) req ();
   rpks_stream_if #(.T(rsp_type)) rsp ();

   ray_pixel_key_sorter_top dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req(req.sink), .rsp(rsp.source)
   );

   // Clock generation.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state: the run being collected and the current mode.
   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      int         key;
   } pixel_entry_type;

   pixel_entry_type run_store[$];
   logic [1:0]   mode_now = MODE_LUM;
   rsp_type      sorted_pixels[$];
   req_type      pending_pixels[$];
   int           error_count = 0;
   int           cycle_count = 0;
   bit           hold_arm = 1'b0;
   bit           hold_used = 1'b0;
   bit           hold_rsp = 1'b0;
   int           hold_cycles = 0;

   function automatic int pixel_key(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                    logic [1:0] mode);
      int mx, mn, d, lum, num;
      mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
      mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
      d = mx - mn;
      lum = 299 * r + 587 * g + 114 * b;
      case (mode)
         MODE_LUM:  return lum;
         MODE_NLUM: return -lum;
         MODE_HUE: begin
            if (d == 0) return 0;
            if (mx == r) num = (g >= b) ? (g - b) : (6 * d - (b - g));
            else if (mx == g) num = 2 * d + b - r;
            else num = 4 * d + r - g;
            return (num * 65536) / d;
         end
         default: begin
            if (mx == 0) return 0;
            return (d * 65536) / mx;
         end
      endcase
   endfunction

   // Insert one accepted pixel while the run has room; on a last beat, queue the sorted run.
   task automatic predict_pixel(req_type px);
      pixel_entry_type e;
      rsp_type o;
      int pos;
      if (run_store.size() < RayDepth) begin
         e.red = px.red; e.green = px.green; e.blue = px.blue;
         e.key = pixel_key(px.red, px.green, px.blue, mode_now);
         pos = run_store.size();
         while (pos > 0 && run_store[pos - 1].key > e.key) pos--;
         run_store.insert(pos, e);
      end
      if (px.last_in) begin
         foreach (run_store[k]) begin
            o.red_out = run_store[k].red;
            o.green_out = run_store[k].green;
            o.blue_out = run_store[k].blue;
            o.last_out = (k == run_store.size() - 1);
            sorted_pixels.push_back(o);
         end
         run_store.delete();
      end
   endtask

   task automatic report(string what, rsp_type got, rsp_type want);
      error_count++;
      $display("MISMATCH %s: got %h/%h/%h/%b want %h/%h/%h/%b", what,
               got.red_out, got.green_out, got.blue_out, got.last_out,
               want.red_out, want.green_out, want.blue_out, want.last_out);
   endtask

   // Driver: offers queued pixels with random gaps.
   int send_gap = 0;
   bit req_fire;
   always @(posedge clock) begin
      req_fire <= req.valid && req.ready && !reset;
      if (!reset && req.valid && req.ready) predict_pixel(req.data);
   end
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.data <= '0;
      end else if (req.valid && !req_fire) begin
         // still waiting for acceptance
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req.valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
         req.data <= pending_pixels.pop_front();
         req.valid <= 1'b1;
         send_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
      end else begin
         req.valid <= 1'b0;
      end
   end

   // Long hold-off: once armed, starts when a result is first offered.
   always @(negedge clock) begin
      if (hold_arm && !hold_used && rsp.valid) begin
         hold_used <= 1'b1;
         hold_rsp <= 1'b1;
         hold_cycles <= 400;
      end else if (hold_rsp) begin
         if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
         else hold_rsp <= 1'b0;
      end
   end

   // Receiver: random stalls, plus the long hold-off.
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_rsp) begin
         rsp.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
         rsp_gap <= $urandom_range(0, 2) == 0 ? $urandom_range(0, 16) : 0;
      end
   end

   // Monitor: checks each sorted beat against the oldest expectation.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp.valid && rsp.ready) begin
         if (sorted_pixels.size() == 0) begin
            report("unexpected beat", rsp.data, '0);
         end else begin
            if (rsp.data.red_out !== sorted_pixels[0].red_out)
               report("red_out", rsp.data, sorted_pixels[0]);
            if (rsp.data.green_out !== sorted_pixels[0].green_out)
               report("green_out", rsp.data, sorted_pixels[0]);
            if (rsp.data.blue_out !== sorted_pixels[0].blue_out)
               report("blue_out", rsp.data, sorted_pixels[0]);
            if (rsp.data.last_out !== sorted_pixels[0].last_out)
               report("last_out", rsp.data, sorted_pixels[0]);
            void'(sorted_pixels.pop_front());
         end
      end
   end

   // Timeout guard.
   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("ray_pixel_key_sorter_top regression: fail");
         $finish;
      end
   end

   function automatic req_type make_pixel(int r, int g, int b, bit last);
      req_type p;
      p.red = 8'(r); p.green = 8'(g); p.blue = 8'(b); p.last_in = last;
      return p;
   endfunction

   // Queue one random run of len pixels; callers favor short runs, a few overflow the store.
   task automatic queue_run(int len, bit sparse);
      int r, g, b;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 255); g = $urandom_range(0, 255);
         b = $urandom_range(0, 255);
         if (sparse && $urandom_range(0, 3) == 0) begin
            r = r & 8'hc0; g = g & 8'hc0; b = b & 8'hc0;   // make equal keys likely
         end
         pending_pixels.push_back(make_pixel(r, g, b, i == len - 1));
      end
   endtask

   // Wait until every queued and expected beat is done, then let the block settle.
   task automatic drain();
      wait (pending_pixels.size() == 0);
      @(posedge clock);
      while (req.valid || sorted_pixels.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_mode(logic [1:0] m);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= m;
      mode_now = m;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   int sent;
   int len;
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, gray ties, hue sectors, single pixel, overflow.
      for (int m = 0; m < 4; m++) begin
         set_mode(m[1:0]);
         pending_pixels.push_back(make_pixel(255, 255, 255, 1'b1));
         pending_pixels.push_back(make_pixel(0, 0, 0, 1'b0));
         pending_pixels.push_back(make_pixel(255, 0, 0, 1'b0));
         pending_pixels.push_back(make_pixel(255, 0, 10, 1'b0));
         pending_pixels.push_back(make_pixel(0, 255, 0, 1'b0));
         pending_pixels.push_back(make_pixel(0, 0, 255, 1'b0));
         pending_pixels.push_back(make_pixel(80, 80, 80, 1'b0));
         pending_pixels.push_back(make_pixel(255, 255, 0, 1'b0));
         pending_pixels.push_back(make_pixel(0, 0, 0, 1'b1));
         drain();
      end
      // Store overflow with the last pixel dropped.
      set_mode(MODE_LUM);
      queue_run(34, 1'b0);
      // Long receiver hold-off while the sender keeps offering.
      hold_arm = 1'b1;
      queue_run(20, 1'b1);
      queue_run(20, 1'b0);
      drain();

      // Random runs under randomly chosen modes, with an idle sender at each switch.
      sent = 0;
      while (sent < 370) begin
         set_mode(2'($urandom_range(0, 3)));
         for (int k = 0; k < 4 && sent < 370; k++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 36)
                                              : $urandom_range(1, 10);
            queue_run(len, $urandom_range(0, 1));
            sent += len;
         end
         drain();
      end

      if (error_count == 0)
         $display("ray_pixel_key_sorter_top regression: pass");
      else
         $display("ray_pixel_key_sorter_top regression: fail");
      $finish;
   end
endmodule
